FILE: rtl/llsa_pkg.sv
// ----------------------------------------------------------------------------
// llsa_pkg: shared types and constants
// Field widths, function codes and the control structs used by the
// least-loaded server assignment block.
// ----------------------------------------------------------------------------
package llsa_pkg;

	localparam int MAX_SERVERS_DEF = 64;
	localparam int LOAD_WIDTH_DEF  = 32;

	localparam int DUR_W  = 20;
	localparam int SRV_W  = 7;
	localparam int CFG_W  = 7;
	localparam int APB_DW = 32;
	localparam int APB_AW = 3;

	localparam logic FUNC_ASSIGN = 1'b0;
	localparam logic FUNC_CLEAR  = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_NUM_SERVERS = 1'b0;

	localparam logic [CFG_W-1:0] NUM_SERVERS_RST = CFG_W'(1);

	// broadcast from the controller to every cell
	typedef struct packed {
		logic clr;
		logic wr;
	} llsa_ctl_t;

	// status of the scan token that walks down the chain
	typedef struct packed {
		logic vld;
		logic has1;
		logic has2;
	} llsa_tok_t;

endpackage

FILE: rtl/llsa_if.sv
// ----------------------------------------------------------------------------
// llsa_if: request and response channels
// Valid/ready channels for job requests and assignment responses.
// ----------------------------------------------------------------------------
interface llsa_req_if import llsa_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             func;
	logic [DUR_W-1:0] duration;

	modport source (output valid, output func, output duration, input ready);
	modport sink   (input valid, input func, input duration, output ready);
endinterface

interface llsa_rsp_if import llsa_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SRV_W-1:0] assigned_server;
	logic [SRV_W-1:0] next_free_server;

	modport source (output valid, output assigned_server, output next_free_server,
		input ready);
	modport sink   (input valid, input assigned_server, input next_free_server,
		output ready);
endinterface

FILE: rtl/least_loaded_server_assignment.sv
// ----------------------------------------------------------------------------
// least_loaded_server_assignment: least-loaded job dispatcher
// Gives each job to the server with the smallest accumulated load and
// reports the server that will be chosen next.
// ----------------------------------------------------------------------------
// A request is taken only while the block is idle. On a job request a scan
// token walks the chain of MAX_SERVERS load cells at one cell per cycle,
// starting at the accepting edge, and collects the two lowest loads in use.
// When the token leaves the last cell, the saturated new load is written
// back and the block enters its done state; it loads the response register
// from there and returns to idle at the same edge. A clear request goes from
// acceptance straight to the done state. A new request is accepted while the
// previous response still waits to be taken. A result that finds the response
// register still full holds the block until that response is taken. Servers
// beyond num_servers are skipped by the scan but keep their loads.
module least_loaded_server_assignment import llsa_pkg::*; #(
	parameter int MAX_SERVERS = MAX_SERVERS_DEF,
	parameter int LOAD_WIDTH  = LOAD_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	llsa_req_if.sink          req,
	llsa_rsp_if.source        rsp
);

	localparam int IDX_W = $clog2(MAX_SERVERS);
	localparam int CNT_W = $clog2(MAX_SERVERS + 1);
	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int SUM_W = ((LOAD_WIDTH > DUR_W) ? LOAD_WIDTH : DUR_W) + 1;
	localparam logic [SUM_W-1:0] LOAD_MAX = SUM_W'({LOAD_WIDTH{1'b1}});

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [CFG_W-1:0] num_servers;

	llsa_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.num_servers (num_servers)
	);

	// effective count: zero acts as one, too large clamps to MAX_SERVERS
	logic [CMP_W-1:0] num_ext;
	logic [CNT_W-1:0] n_eff;
	logic [IDX_W-1:0] last_idx;

	assign num_ext = CMP_W'(num_servers);

	always_comb begin
		if (num_servers == '0) begin
			n_eff = CNT_W'(1);
		end else if (num_ext > CMP_W'(MAX_SERVERS)) begin
			n_eff = CNT_W'(MAX_SERVERS);
		end else begin
			n_eff = CNT_W'(num_ext);
		end
	end

	assign last_idx = IDX_W'(n_eff - CNT_W'(1));

	logic [1:0]            state_q;
	logic [DUR_W-1:0]      dur_q;
	logic [SRV_W-1:0]      pend_a_q, pend_n_q;
	logic                  rsp_valid_q;
	logic [SRV_W-1:0]      rsp_a_q, rsp_n_q;

	logic                  acc;
	logic                  rsp_free;
	llsa_ctl_t             ctl;
	logic [IDX_W-1:0]      wr_idx;
	logic [LOAD_WIDTH-1:0] wr_data;

	llsa_tok_t             tok [MAX_SERVERS+1];
	logic [LOAD_WIDTH-1:0] v1  [MAX_SERVERS+1];
	logic [IDX_W-1:0]      i1  [MAX_SERVERS+1];
	logic [LOAD_WIDTH-1:0] v2  [MAX_SERVERS+1];
	logic [IDX_W-1:0]      i2  [MAX_SERVERS+1];

	assign req.ready = (state_q == ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	// token enters cell 0 on a job request
	assign tok[0] = {acc && (req.func == FUNC_ASSIGN), 1'b0, 1'b0};
	assign v1[0]  = '0;
	assign i1[0]  = '0;
	assign v2[0]  = '0;
	assign i2[0]  = '0;

	for (genvar k = 0; k < MAX_SERVERS; k++) begin : g_cell
		llsa_cell #(
			.K          (k),
			.IDX_W      (IDX_W),
			.LOAD_WIDTH (LOAD_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.wr_idx   (wr_idx),
			.wr_data  (wr_data),
			.last_idx (last_idx),
			.tok_in   (tok[k]),
			.v1_in    (v1[k]),
			.i1_in    (i1[k]),
			.v2_in    (v2[k]),
			.i2_in    (i2[k]),
			.tok_out  (tok[k+1]),
			.v1_out   (v1[k+1]),
			.i1_out   (i1[k+1]),
			.v2_out   (v2[k+1]),
			.i2_out   (i2[k+1])
		);
	end

	// write-back of the winner with saturation, and the next pick
	llsa_tok_t             tok_end;
	logic [SUM_W-1:0]      sum;
	logic [LOAD_WIDTH-1:0] new_load;
	logic [IDX_W-1:0]      next_idx;
	logic [IDX_W:0]        a_inc, n_inc;

	assign tok_end  = tok[MAX_SERVERS];
	assign sum      = SUM_W'(v1[MAX_SERVERS]) + SUM_W'(dur_q);
	assign new_load = (sum > LOAD_MAX) ? {LOAD_WIDTH{1'b1}} : sum[LOAD_WIDTH-1:0];

	always_comb begin
		next_idx = i1[MAX_SERVERS];
		if (tok_end.has2) begin
			if (v2[MAX_SERVERS] < new_load ||
				(v2[MAX_SERVERS] == new_load && i2[MAX_SERVERS] < i1[MAX_SERVERS])) begin
				next_idx = i2[MAX_SERVERS];
			end
		end
	end

	assign a_inc = {1'b0, i1[MAX_SERVERS]} + (IDX_W+1)'(1);
	assign n_inc = {1'b0, next_idx} + (IDX_W+1)'(1);

	always_comb begin
		ctl.clr = acc && (req.func == FUNC_CLEAR);
		ctl.wr  = (state_q == ST_SCAN) && tok_end.vld;
		wr_idx  = i1[MAX_SERVERS];
		wr_data = new_load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						state_q <= (req.func == FUNC_CLEAR) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tok_end.vld) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			dur_q    <= req.duration;
			pend_a_q <= '0;
			pend_n_q <= SRV_W'(1);
		end
		if (ctl.wr) begin
			pend_a_q <= SRV_W'(a_inc);
			pend_n_q <= SRV_W'(n_inc);
		end
		if (state_q == ST_DONE && rsp_free) begin
			rsp_a_q <= pend_a_q;
			rsp_n_q <= pend_n_q;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.assigned_server  = rsp_a_q;
	assign rsp.next_free_server = rsp_n_q;

	a_tok_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok_end.vld |-> state_q == ST_SCAN)
		else $error("scan token left the chain outside a scan");

	a_no_clr_wr: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.clr && ctl.wr))
		else $error("clear and write-back in the same cycle");

	a_job_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.func == FUNC_ASSIGN) |=> state_q == ST_SCAN)
		else $error("job request did not start a scan");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("response raised outside the done state");

endmodule

FILE: rtl/llsa_cell.sv
// ----------------------------------------------------------------------------
// llsa_cell: one server slot of the scan chain
// Holds one server load. A passing scan token keeps the best and second
// best (load, index) seen so far; the cell folds its own load in when the
// server is in use and hands the token to its neighbor in the next cycle.
// ----------------------------------------------------------------------------
module llsa_cell import llsa_pkg::*; #(
	parameter int K          = 0,
	parameter int IDX_W      = 6,
	parameter int LOAD_WIDTH = LOAD_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  llsa_ctl_t             ctl,
	input  logic [IDX_W-1:0]      wr_idx,
	input  logic [LOAD_WIDTH-1:0] wr_data,
	input  logic [IDX_W-1:0]      last_idx,
	input  llsa_tok_t             tok_in,
	input  logic [LOAD_WIDTH-1:0] v1_in,
	input  logic [IDX_W-1:0]      i1_in,
	input  logic [LOAD_WIDTH-1:0] v2_in,
	input  logic [IDX_W-1:0]      i2_in,
	output llsa_tok_t             tok_out,
	output logic [LOAD_WIDTH-1:0] v1_out,
	output logic [IDX_W-1:0]      i1_out,
	output logic [LOAD_WIDTH-1:0] v2_out,
	output logic [IDX_W-1:0]      i2_out
);

	localparam logic [IDX_W-1:0] KI = IDX_W'(K);

	logic [LOAD_WIDTH-1:0] load_q;
	llsa_tok_t             tok_q;
	logic [LOAD_WIDTH-1:0] v1_q, v2_q;
	logic [IDX_W-1:0]      i1_q, i2_q;

	logic                  active;
	llsa_tok_t             tok_d;
	logic [LOAD_WIDTH-1:0] v1_d, v2_d;
	logic [IDX_W-1:0]      i1_d, i2_d;

	assign active = (KI <= last_idx);

	// indices arrive in increasing order, so strict less keeps the lower index
	always_comb begin
		tok_d = tok_in;
		v1_d  = v1_in;
		i1_d  = i1_in;
		v2_d  = v2_in;
		i2_d  = i2_in;
		if (tok_in.vld && active) begin
			if (!tok_in.has1 || load_q < v1_in) begin
				tok_d.has1 = 1'b1;
				tok_d.has2 = tok_in.has1;
				v1_d       = load_q;
				i1_d       = KI;
				v2_d       = v1_in;
				i2_d       = i1_in;
			end else if (!tok_in.has2 || load_q < v2_in) begin
				tok_d.has2 = 1'b1;
				v2_d       = load_q;
				i2_d       = KI;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= '0;
			tok_q  <= '0;
		end else begin
			if (ctl.clr) begin
				load_q <= '0;
			end else if (ctl.wr && wr_idx == KI) begin
				load_q <= wr_data;
			end
			tok_q <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		v1_q <= v1_d;
		i1_q <= i1_d;
		v2_q <= v2_d;
		i2_q <= i2_d;
	end

	assign tok_out = tok_q;
	assign v1_out  = v1_q;
	assign i1_out  = i1_q;
	assign v2_out  = v2_q;
	assign i2_out  = i2_q;

endmodule

FILE: rtl/llsa_cfg.sv
// ----------------------------------------------------------------------------
// llsa_cfg: configuration register port
// APB-style access to the server count register.
// ----------------------------------------------------------------------------
module llsa_cfg import llsa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output logic [CFG_W-1:0]  num_servers
);

	logic [CFG_W-1:0] num_q;
	logic             hit;

	assign hit    = (paddr[2] == REG_NUM_SERVERS);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= NUM_SERVERS_RST;
		end else if (psel && penable && pwrite && hit) begin
			num_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata      = hit ? APB_DW'(num_q) : '0;
	assign num_servers = num_q;

endmodule
